// ===== sv/sld_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sld_pkg
// Shared types and constants for the sync/length/checksum frame deframer.
// ----------------------------------------------------------------------------
package sld_pkg;

  // Frame format
  localparam logic [7:0] SYNC_BYTE      = 8'h55;
  localparam int         FRAME_CAPACITY = 256;
  localparam int         FRAME_OVERHEAD = 4;
  localparam int         LEN_POS        = 2;

  // Counter widths: held count must reach the capacity, totals reach 255 + 4
  localparam int HELD_W  = 9;
  localparam int TOTAL_W = 9;
  localparam int IDLE_W  = 16;

  // Configuration port
  localparam int                APB_ADDR_W      = 3;
  localparam int                APB_DATA_W      = 32;
  localparam logic              REG_IDLE_TIMEOUT = 1'b0;
  localparam logic [IDLE_W-1:0] TIMEOUT_RESET   = 16'd5000;

  // Result event codes
  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_SKIP     = 3'd1,
    EV_ACCEPT   = 3'd2,
    EV_GOOD     = 3'd3,
    EV_BAD      = 3'd4,
    EV_OVERFLOW = 3'd5,
    EV_TIMEOUT  = 3'd6
  } event_t;

endpackage

// ===== sv/sld_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sld_in_if / sld_out_if
// Valid/ready channels for received items and for deframer events.
// ----------------------------------------------------------------------------
interface sld_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;

  modport source (output valid, func, rx_byte, input ready);
  modport sink   (input valid, func, rx_byte, output ready);
  modport mon    (input valid, ready, func, rx_byte);
endinterface

interface sld_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [7:0] byte_out;
  logic [7:0] position;

  modport source (output valid, event_res, byte_out, position, input ready);
  modport sink   (input valid, event_res, byte_out, position, output ready);
  modport mon    (input valid, ready, event_res, byte_out, position);
endinterface

// ===== sv/sync_length_checksum_deframer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer_unit
// Hunts for 0x55, collects a length-prefixed frame, checks its 8-bit sum.
// ----------------------------------------------------------------------------
// Usage:
//   rx_chan carries one item per transfer: a received byte (func = 0) or one
//   idle tick (func = 1). Every input transfer yields exactly one result on
//   ev_chan: event code, the accepted byte and its position in the frame.
//   The last byte of a frame reports good or bad checksum; an overflowing
//   byte or an idle timeout discards the partial frame.
//   The result is registered at the edge the input transfer completes.
//   Throughput is one item per cycle while the receiver takes each result, set by
//   the single state update (count, sum, length) and the result register.
//   When the receiver stalls, the result register holds; a new input is
//   taken in the same cycle that the held result is taken (rx ready follows
//   ev ready combinationally while a result waits).
//   The idle timeout register sits at byte address 0 of the APB port;
//   writes complete in the access cycle, pready is tied high.
//   Reset (rst, synchronous) empties the result register, clears the frame
//   state and idle count and loads the timeout with 5000 ticks.
// ----------------------------------------------------------------------------
module sync_length_checksum_deframer_unit (
  input  logic                              clk,
  input  logic                              rst,
  sld_in_if.sink                            rx_chan,
  sld_out_if.source                         ev_chan,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sld_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [sld_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [sld_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import sld_pkg::*;

  localparam logic [HELD_W-1:0]  CAP_CNT  = HELD_W'(FRAME_CAPACITY);
  localparam logic [HELD_W-1:0]  OVH_CNT  = HELD_W'(FRAME_OVERHEAD);
  localparam logic [HELD_W-1:0]  LEN_CNT  = HELD_W'(LEN_POS);
  localparam logic [TOTAL_W-1:0] OVH_TOT  = TOTAL_W'(FRAME_OVERHEAD);
  localparam logic [IDLE_W-1:0]  IDLE_MAX = '1;

  // Configuration
  logic [IDLE_W-1:0] idle_timeout;
  logic              reg_index;
  logic              cfg_write;

  // Frame state
  logic [HELD_W-1:0]  bytes_held,     bytes_held_next;
  logic [TOTAL_W-1:0] expected_total, expected_total_next;
  logic [7:0]         running_sum,    running_sum_next;
  logic [IDLE_W-1:0]  idle_count,     idle_count_next;

  // Result register
  logic       res_valid;
  event_t     res_event,    res_event_next;
  logic [7:0] res_byte,     res_byte_next;
  logic [7:0] res_position, res_position_next;

  logic              in_xfer;
  logic [HELD_W-1:0] held_inc;
  logic [IDLE_W-1:0] idle_inc;

  // APB register access
  assign pready    = 1'b1;
  assign reg_index = paddr[APB_ADDR_W-1];
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    if (reg_index == REG_IDLE_TIMEOUT) begin
      prdata = APB_DATA_W'(idle_timeout);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout <= TIMEOUT_RESET;
    end else if (cfg_write && reg_index == REG_IDLE_TIMEOUT) begin
      idle_timeout <= pwdata[IDLE_W-1:0];
    end
  end

  // Handshake: take an item whenever the result slot is free or draining
  assign rx_chan.ready = !res_valid || ev_chan.ready;
  assign in_xfer       = rx_chan.valid && rx_chan.ready;

  assign held_inc = bytes_held + HELD_W'(1);
  assign idle_inc = (idle_count == IDLE_MAX) ? idle_count : idle_count + IDLE_W'(1);

  // Per-item update of frame state and result
  always_comb begin
    bytes_held_next     = bytes_held;
    expected_total_next = expected_total;
    running_sum_next    = running_sum;
    idle_count_next     = idle_count;
    res_event_next      = EV_NONE;
    res_byte_next       = '0;
    res_position_next   = '0;

    if (rx_chan.func) begin
      // time tick
      idle_count_next = idle_inc;
      if (idle_inc > idle_timeout && bytes_held != '0) begin
        bytes_held_next     = '0;
        expected_total_next = '0;
        running_sum_next    = '0;
        res_event_next      = EV_TIMEOUT;
      end
    end else begin
      idle_count_next = '0;
      if (bytes_held == '0 && rx_chan.rx_byte != SYNC_BYTE) begin
        res_event_next = EV_SKIP;
      end else if (bytes_held >= CAP_CNT) begin
        bytes_held_next     = '0;
        expected_total_next = '0;
        running_sum_next    = '0;
        res_event_next      = EV_OVERFLOW;
      end else begin
        bytes_held_next   = held_inc;
        res_byte_next     = rx_chan.rx_byte;
        res_position_next = bytes_held[7:0];
        if (bytes_held == LEN_CNT) begin
          expected_total_next = TOTAL_W'(rx_chan.rx_byte) + OVH_TOT;
        end
        if (held_inc >= OVH_CNT && TOTAL_W'(held_inc) >= expected_total_next) begin
          // last byte: compare against the sum of everything before it
          res_event_next      = (running_sum == rx_chan.rx_byte) ? EV_GOOD : EV_BAD;
          bytes_held_next     = '0;
          expected_total_next = '0;
          running_sum_next    = '0;
        end else begin
          running_sum_next = running_sum + rx_chan.rx_byte;
          res_event_next   = EV_ACCEPT;
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_held     <= '0;
      expected_total <= '0;
      running_sum    <= '0;
      idle_count     <= '0;
    end else if (in_xfer) begin
      bytes_held     <= bytes_held_next;
      expected_total <= expected_total_next;
      running_sum    <= running_sum_next;
      idle_count     <= idle_count_next;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (in_xfer) begin
      res_valid <= 1'b1;
    end else if (ev_chan.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_event    <= res_event_next;
      res_byte     <= res_byte_next;
      res_position <= res_position_next;
    end
  end

  assign ev_chan.valid     = res_valid;
  assign ev_chan.event_res = res_event;
  assign ev_chan.byte_out  = res_byte;
  assign ev_chan.position  = res_position;

endmodule

// ===== sv/sld_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sld_checker
// Port-level checks for the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module sld_checker (
  input logic       clk,
  input logic       rst,
  sld_in_if.sink    rx_chan,
  sld_out_if.source ev_chan
);
  import sld_pkg::*;

  // No result pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !ev_chan.valid)
    else $error("result valid after reset");

  // Every input transfer produces a result in the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (rx_chan.valid && rx_chan.ready) |=> ev_chan.valid)
    else $error("input transfer without result");

  // An empty result slot never blocks input
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !ev_chan.valid |-> rx_chan.ready)
    else $error("input stalled with empty result slot");

  // Byte and position are zero unless a byte was taken into a frame
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (ev_chan.valid && ev_chan.event_res != EV_ACCEPT && ev_chan.event_res != EV_GOOD
      && ev_chan.event_res != EV_BAD)
      |-> (ev_chan.byte_out == 8'd0 && ev_chan.position == 8'd0))
    else $error("nonzero byte or position on non-accept event");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (ev_chan.valid && !ev_chan.ready) |=> (ev_chan.valid && $stable(ev_chan.event_res)
      && $stable(ev_chan.byte_out) && $stable(ev_chan.position)))
    else $error("stalled result changed");

endmodule

bind sync_length_checksum_deframer_unit sld_checker u_sld_checker (
  .clk     (clk),
  .rst     (rst),
  .rx_chan (rx_chan),
  .ev_chan (ev_chan)
);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sync/length/checksum frame deframer.
// A queue-fed driver offers received bytes and idle ticks on rx_chan.
// A monitor predicts one event per input transfer and checks each event
// transfer on ev_chan against the oldest prediction. The idle timeout is
// reprogrammed over APB between phases. The phases cover directed edge
// cases, random frames under several idle patterns, and long frames that
// hit capacity.
// ----------------------------------------------------------------------------
module tb;
  import sld_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam int HOLD_CYCLES  = 300;
  localparam int SHOW_ERRORS  = 10;

  // APB byte addresses
  localparam logic [APB_ADDR_W-1:0] ADDR_IDLE_TIMEOUT = APB_ADDR_W'(4 * REG_IDLE_TIMEOUT);
  localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED     = 3'd4;

  typedef struct packed {
    logic       is_tick;
    logic [7:0] data;
  } rx_item_t;

  typedef struct packed {
    event_t     ev;
    logic [7:0] data;
    logic [7:0] pos;
  } deframe_result_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  sld_in_if  rx_if ();
  sld_out_if ev_if ();

  sync_length_checksum_deframer_unit uut (
    .clk     (clk),
    .rst     (rst),
    .rx_chan (rx_if),
    .ev_chan (ev_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Pending inputs and predicted events
  rx_item_t        pend_q[$];
  deframe_result_t event_q[$];
  rx_item_t        drv_item;
  deframe_result_t seen_exp;

  // Deframer shadow state
  logic [HELD_W-1:0]  held_cnt    = '0;
  logic [TOTAL_W-1:0] frame_total = '0;
  logic [7:0]         frame_sum   = '0;
  logic [IDLE_W-1:0]  idle_ticks  = '0;
  logic [IDLE_W-1:0]  timeout_cfg = TIMEOUT_RESET;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic hold_start = 1'b0;
  int hold_left;
  int errors = 0;
  int cycles = 0;
  int inputs_done = 0;
  int ev_seen[0:7];
  int holds_done = 0;

  // Clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Known values on all inputs from time zero
  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rx_if.valid = 1'b0;
    rx_if.func = 1'b0;
    rx_if.rx_byte = 8'd0;
    ev_if.ready = 1'b0;
    for (int i = 0; i < 8; i++) ev_seen[i] = 0;
  end

  function automatic void note_error(input string msg);
    errors++;
    if (errors <= SHOW_ERRORS) $display("ERROR: %s", msg);
  endfunction

  // Shadow deframer: one event per input item
  function automatic deframe_result_t deframe_step(input logic is_tick, input logic [7:0] b);
    deframe_result_t r;
    logic [HELD_W-1:0] slot;
    r.ev = EV_NONE;
    r.data = 8'd0;
    r.pos = 8'd0;
    if (is_tick) begin
      if (idle_ticks != {IDLE_W{1'b1}}) idle_ticks = idle_ticks + 1'b1;
      if (idle_ticks > timeout_cfg && held_cnt != 0) begin
        held_cnt = '0;
        frame_total = '0;
        frame_sum = '0;
        r.ev = EV_TIMEOUT;
      end
      return r;
    end
    idle_ticks = '0;
    // hunting: anything but the sync byte is skipped
    if (held_cnt == 0 && b != SYNC_BYTE) begin
      r.ev = EV_SKIP;
      return r;
    end
    if (held_cnt >= FRAME_CAPACITY) begin
      held_cnt = '0;
      frame_total = '0;
      frame_sum = '0;
      r.ev = EV_OVERFLOW;
      return r;
    end
    slot = held_cnt;
    held_cnt = held_cnt + 1'b1;
    if (slot == LEN_POS) frame_total = TOTAL_W'(b) + TOTAL_W'(FRAME_OVERHEAD);
    r.data = b;
    r.pos = slot[7:0];
    if (held_cnt >= FRAME_OVERHEAD && held_cnt >= frame_total) begin
      r.ev = (frame_sum == b) ? EV_GOOD : EV_BAD;
      held_cnt = '0;
      frame_total = '0;
      frame_sum = '0;
    end else begin
      frame_sum = frame_sum + b;
      r.ev = EV_ACCEPT;
    end
    return r;
  endfunction

  // Driver: offers the next pending item, with random gaps
  always @(posedge clk) begin
    if (rst) begin
      rx_if.valid <= 1'b0;
    end else if (!rx_if.valid || rx_if.ready) begin
      if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_item = pend_q.pop_front();
        rx_if.valid <= 1'b1;
        rx_if.func <= drv_item.is_tick;
        rx_if.rx_byte <= drv_item.data;
      end else begin
        rx_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off when requested
  always @(posedge clk) begin
    if (rst) begin
      ev_if.ready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (hold_start) begin
        hold_left <= HOLD_CYCLES;
        holds_done <= holds_done + 1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
      ev_if.ready <= !hold_start && hold_left == 0 && $urandom_range(99) >= recv_idle_pct;
    end
  end

  // Monitor: check event transfers, then predict for the input transfer
  always @(posedge clk) begin
    if (!rst) begin
      if (ev_if.valid && ev_if.ready) begin
        ev_seen[ev_if.event_res]++;
        if (event_q.size() == 0) begin
          note_error($sformatf("unexpected event %0d byte %02h pos %0d",
                               ev_if.event_res, ev_if.byte_out, ev_if.position));
        end else begin
          seen_exp = event_q.pop_front();
          if (ev_if.event_res !== seen_exp.ev || ev_if.byte_out !== seen_exp.data ||
              ev_if.position !== seen_exp.pos)
            note_error($sformatf("event exp %0d/%02h/%0d got %0d/%02h/%0d",
                                 seen_exp.ev, seen_exp.data, seen_exp.pos,
                                 ev_if.event_res, ev_if.byte_out, ev_if.position));
        end
      end
      if (rx_if.valid && rx_if.ready) begin
        event_q.insert(event_q.size(), deframe_step(rx_if.func, rx_if.rx_byte));
        inputs_done++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout: %0d items pending, %0d events outstanding",
               pend_q.size(), event_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // APB transfers
  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_IDLE_TIMEOUT) timeout_cfg = data[IDLE_W-1:0];
  endtask

  task automatic check_timeout_reg();
    logic [31:0] rd;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_IDLE_TIMEOUT;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd[IDLE_W-1:0] !== timeout_cfg)
      note_error($sformatf("timeout readback exp %0d got %0d", timeout_cfg, rd[IDLE_W-1:0]));
  endtask

  // Stimulus builders
  task automatic push_byte(input logic [7:0] b);
    pend_q.insert(pend_q.size(), rx_item_t'{is_tick: 1'b0, data: b});
  endtask

  task automatic push_ticks(input int n);
    for (int i = 0; i < n; i++)
      pend_q.insert(pend_q.size(), rx_item_t'{is_tick: 1'b1, data: 8'($urandom)});
  endtask

  // Well-formed frame; optional bad checksum and stray ticks between bytes
  task automatic push_frame(input int len, input bit corrupt, input int tick_pct);
    logic [7:0] sum;
    logic [7:0] b;
    sum = SYNC_BYTE;
    push_byte(SYNC_BYTE);
    for (int i = 1; i < len + FRAME_OVERHEAD - 1; i++) begin
      b = (i == LEN_POS) ? 8'(len) : 8'($urandom);
      if ($urandom_range(99) < tick_pct) push_ticks($urandom_range(1, 3));
      push_byte(b);
      sum = sum + b;
    end
    push_byte(corrupt ? sum ^ 8'($urandom_range(1, 255)) : sum);
  endtask

  task automatic push_random(input int n);
    int cnt;
    int r;
    int k;
    cnt = 0;
    while (cnt < n) begin
      r = $urandom_range(99);
      if (r < 60) begin
        k = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        push_frame(k, $urandom_range(4) == 0, 8);
        cnt += k + FRAME_OVERHEAD;
      end else if (r < 70) begin
        // truncated frame left to time out
        k = $urandom_range(1, 5);
        push_byte(SYNC_BYTE);
        for (int i = 1; i < k; i++) push_byte(8'($urandom));
        push_ticks($urandom_range(1, 30));
        cnt += k;
      end else if (r < 85) begin
        // line noise, mostly skipped while hunting
        for (int i = 0; i < $urandom_range(1, 5); i++) push_byte(8'($urandom));
      end else if (r < 95) begin
        k = $urandom_range(1, 30);
        push_ticks(k);
        cnt += k;
      end else begin
        // sync followed by garbage of random length byte
        k = $urandom_range(2, 12);
        push_byte(SYNC_BYTE);
        for (int i = 1; i < k; i++) push_byte(8'($urandom));
        cnt += k;
      end
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pend_q.size() != 0 || rx_if.valid || event_q.size() != 0) @(negedge clk);
  endtask

  // Test sequence
  initial begin
    logic [15:0] tmo;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    check_timeout_reg();

    // Directed: hunting, shortest good frame, bad checksum, tick with nothing held
    push_ticks(1);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(SYNC_BYTE);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(8'h54);
    push_byte(SYNC_BYTE);
    push_byte(8'h00);
    push_byte(8'h01);
    push_byte(8'hAA);
    push_byte(8'h01);
    wait_drained();

    // Directed: zero timeout discards on the first tick; unmapped write ignored
    apb_write(ADDR_IDLE_TIMEOUT, 32'd0);
    push_byte(SYNC_BYTE);
    push_byte(8'h12);
    push_ticks(2);
    wait_drained();
    apb_write(ADDR_UNMAPPED, 32'd7);
    check_timeout_reg();

    // Directed: a byte restarts the idle count
    apb_write(ADDR_IDLE_TIMEOUT, 32'd2);
    push_byte(SYNC_BYTE);
    push_ticks(2);
    push_byte(8'h00);
    push_ticks(3);
    wait_drained();

    // Random phases: sender sparse idle, then receiver sparse idle, then none
    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 9 : (mode == 1) ? 58 : 0;
      recv_idle_pct = (mode == 0) ? 58 : (mode == 1) ? 9 : 0;
      for (int sub = 0; sub < 2; sub++) begin
        case (mode * 2 + sub)
          0: tmo = 16'd3;
          1: tmo = 16'($urandom_range(0, 15));
          2: tmo = 16'hFFFF;
          3: tmo = 16'($urandom);
          4: tmo = 16'($urandom_range(1, 10));
          default: tmo = 16'd0;
        endcase
        apb_write(ADDR_IDLE_TIMEOUT, {16'd0, tmo});
        check_timeout_reg();
        push_random(70);
        if (mode == 2 && sub == 0) begin
          // long receiver hold-off while the sender keeps offering
          @(posedge clk);
          hold_start <= 1'b1;
          @(posedge clk);
          hold_start <= 1'b0;
        end
        wait_drained();
      end
    end

    // Long frames: exactly at capacity, then length byte 255, which overruns it
    apb_write(ADDR_IDLE_TIMEOUT, 32'd40);
    push_frame(FRAME_CAPACITY - FRAME_OVERHEAD, 1'b0, 0);
    push_frame(255, 1'b0, 0);
    push_frame(2, 1'b0, 0);
    wait_drained();

    repeat (5) @(posedge clk);
    $display("Covered %0d input transfers over 10 timeout settings, %0d long hold-off(s).",
             inputs_done, holds_done);
    $display("Events: good %0d, bad %0d, overflow %0d, timeout %0d, skip %0d, accept %0d.",
             ev_seen[EV_GOOD], ev_seen[EV_BAD], ev_seen[EV_OVERFLOW],
             ev_seen[EV_TIMEOUT], ev_seen[EV_SKIP], ev_seen[EV_ACCEPT]);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
